FILE: hw/rtl/pwm_pdc_pkg.sv
// Package for the PWM period/duty calculator: item types, fixed constants,
// and the lane record passed along the divider cell chain. No dependencies.
`timescale 1ns / 1ps

package pwm_pdc_pkg;

    // Fixed figures of the PWM clock tree.
    localparam int unsigned FREQ_MIN_HZ   = 10;
    localparam int unsigned FREQ_MAX_HZ   = 20000;
    localparam int unsigned OSC_RATE_HZ   = 54000000;
    localparam int unsigned FIXED_DIVISOR = 16;
    localparam int unsigned PCT_SCALE     = 100;

    // Field widths.
    localparam int unsigned FREQ_W  = 16;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned RANGE_W = 19;
    localparam int unsigned MARK_W  = 20;

    // OSC / (16 * f) == (OSC / 16) / f, and OSC is a multiple of 16.
    localparam int unsigned DIVIDEND_VAL = OSC_RATE_HZ / FIXED_DIVISOR;
    localparam int unsigned DIV_STEPS    = $clog2(DIVIDEND_VAL + 1);
    localparam logic [DIV_STEPS-1:0] DIVIDEND = DIV_STEPS'(DIVIDEND_VAL);

    // Divisor (clamped frequency) and remainder width.
    localparam int unsigned DVS_W = $clog2(FREQ_MAX_HZ + 1);

    // Mark division: x / 100 == (x >> 2) / 25, done as a multiply by
    // ceil(2^30 / 25). Error term is 1, exact for every product below 2^30.
    localparam int unsigned PROD_W      = RANGE_W + DUTY_W;
    localparam int unsigned QTR_W       = PROD_W - 2;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + (PCT_SCALE / 4) - 1) / (PCT_SCALE / 4);
    localparam int unsigned RECIP_W = $clog2(RECIP_VAL + 1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int unsigned SCALED_W = QTR_W + RECIP_W;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic [DUTY_W-1:0] duty_pct;
    } pwm_pdc_in_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_word;
        logic [MARK_W-1:0]  mark_word;
    } pwm_pdc_out_t;

    // State handed from one divider cell to the next.
    typedef struct packed {
        logic [DVS_W-1:0]     rem;
        logic [DVS_W-1:0]     divisor;
        logic [DIV_STEPS-1:0] quo;
        logic [DUTY_W-1:0]    duty;
    } pwm_pdc_lane_t;

endpackage

FILE: hw/rtl/pwm_pdc_div_cell.sv
// One restoring-division cell: brings in one constant dividend bit, does a
// trial subtract, and registers the lane. Depends on pwm_pdc_pkg.
`timescale 1ns / 1ps

module pwm_pdc_div_cell
    import pwm_pdc_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  pwm_pdc_lane_t in_lane,
    output logic          out_valid,
    input  logic          out_ready,
    output pwm_pdc_lane_t out_lane
);

    localparam logic DVD_BIT = DIVIDEND[DIV_STEPS-1-STEP];

    logic          valid_reg;
    pwm_pdc_lane_t lane_reg;
    pwm_pdc_lane_t lane_next;
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    always_comb begin
        trial = {in_lane.rem, DVD_BIT};
        diff  = trial - {1'b0, in_lane.divisor};
        fits  = (trial >= {1'b0, in_lane.divisor});
        lane_next         = in_lane;
        lane_next.rem     = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        lane_next.quo     = {in_lane.quo[DIV_STEPS-2:0], fits};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lane_reg <= lane_next;
        end
    end

    // Partial remainder always stays below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (lane_reg.rem < lane_reg.divisor))
        else $error("div cell remainder not below divisor");

    // Divisor was clamped before entering the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (lane_reg.divisor >= DVS_W'(FREQ_MIN_HZ)
                       && lane_reg.divisor <= DVS_W'(FREQ_MAX_HZ)))
        else $error("div cell divisor outside clamp range");

endmodule

FILE: hw/rtl/pwm_pdc_mark.sv
// Mark count stages: period * duty, then divide by 100 through a reciprocal
// multiply. Two registered stages with local flow control. Uses pwm_pdc_pkg.
`timescale 1ns / 1ps

module pwm_pdc_mark
    import pwm_pdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [RANGE_W-1:0] in_range,
    input  logic [DUTY_W-1:0]  in_duty,
    output logic               out_valid,
    input  logic               out_ready,
    output pwm_pdc_out_t       out_item
);

    logic                v1_reg;
    logic [RANGE_W-1:0]  range1_reg;
    logic [QTR_W-1:0]    qtr1_reg;
    logic                v2_reg;
    pwm_pdc_out_t        item2_reg;
    logic                ready1;
    logic                ready2;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    assign prod   = PROD_W'(in_range) * PROD_W'(in_duty);
    assign scaled = SCALED_W'(qtr1_reg) * SCALED_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            range1_reg <= in_range;
            qtr1_reg   <= prod[PROD_W-1:2];
        end
        if (ready2 && v1_reg) begin
            item2_reg.range_word <= range1_reg;
            item2_reg.mark_word  <= scaled[RECIP_SHIFT +: MARK_W];
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;

endmodule

FILE: hw/rtl/pwm_pwm_period_duty_calc_unit.sv
// Empty unit, holds no logic; the top level is in pwm_period_duty_calc_unit.sv.
// No dependencies.
`timescale 1ns / 1ps

FILE: hw/rtl/pwm_period_duty_calc_unit.sv
// Top level of the PWM period/duty calculator: frequency clamp, divider
// cell chain, mark stages. Depends on pwm_pdc_pkg, pwm_pdc_div_cell, pwm_pdc_mark.
//
//   channel | ports                      | item contents
//   --------+----------------------------+-------------------------------
//   input   | s_valid, s_ready, s_data   | freq_hz (16b), duty_pct (8b)
//   result  | m_valid, m_ready, m_data   | range_word (19b), mark_word (20b)
//
// One item per cycle sustained while m_ready stays high; the pipeline holds
// the 22 restoring-division cells plus the multiply and reciprocal stages.
// Each stage is ready when empty or when the stage after it moves, so bubbles
// are filled while the result register waits on m_ready.
// Reset (aresetn low, synchronous) clears only the valid bits; the data registers
// are not reset, and results are independent of each other.
`timescale 1ns / 1ps

module pwm_period_duty_calc_unit
    import pwm_pdc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  pwm_pdc_in_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output pwm_pdc_out_t m_data
);

    // Clamp frequency to the legal range; the clamped value fits DVS_W bits.
    logic [FREQ_W-1:0] freq_clamped;
    always_comb begin
        if (s_data.freq_hz > FREQ_W'(FREQ_MAX_HZ)) begin
            freq_clamped = FREQ_W'(FREQ_MAX_HZ);
        end else if (s_data.freq_hz < FREQ_W'(FREQ_MIN_HZ)) begin
            freq_clamped = FREQ_W'(FREQ_MIN_HZ);
        end else begin
            freq_clamped = s_data.freq_hz;
        end
    end

    // Chain links: index k is the input side of cell k, DIV_STEPS the tail.
    logic [DIV_STEPS:0] link_valid;
    logic [DIV_STEPS:0] link_ready;
    pwm_pdc_lane_t      link_lane [DIV_STEPS+1];

    assign link_valid[0]        = s_valid;
    assign s_ready              = link_ready[0];
    assign link_lane[0].rem     = '0;
    assign link_lane[0].divisor = freq_clamped[DVS_W-1:0];
    assign link_lane[0].quo     = '0;
    assign link_lane[0].duty    = s_data.duty_pct;

    // One cell per quotient bit, MSB first.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        pwm_pdc_div_cell #(
            .STEP(k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_lane   (link_lane[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_lane  (link_lane[k+1])
        );
    end

    // Quotient never exceeds 337500, so the low RANGE_W bits carry it all.
    pwm_pdc_mark u_mark (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[DIV_STEPS]),
        .in_ready  (link_ready[DIV_STEPS]),
        .in_range  (link_lane[DIV_STEPS].quo[RANGE_W-1:0]),
        .in_duty   (link_lane[DIV_STEPS].duty),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

    // Period always lands in the range reachable from clamped frequencies.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.range_word >= RANGE_W'(168)
                     && m_data.range_word <= RANGE_W'(337500)))
        else $error("range_word outside reachable period range");

    // Full chain of ready links: an empty result register frees every stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Reset drops any item in flight.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for pwm_period_duty_calc_unit: directed table, then random items,
// scored against a behavioral model of the period/mark math. Depends on pwm_pdc_pkg.
`timescale 1ns / 1ps

module tb_top;
    import pwm_pdc_pkg::*;

    localparam int RAND_BLOCKS    = 30;
    localparam int BLOCK_ITEMS    = 51;
    localparam int HOLD_CYCLES    = 300;   // long sink stall, well past pipeline depth
    localparam int DRAIN_CYCLES   = 40;    // extra wait after the last expected result, as margin
    localparam int NUM_DIRECTED   = 18;

    // One row of the directed table. 'known' marks rows whose words are typed in;
    // the rest are scored against the model.
    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [DUTY_W-1:0]  duty;
        logic               known;
        logic [RANGE_W-1:0] range_word;
        logic [MARK_W-1:0]  mark_word;
    } dir_row_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    pwm_pdc_in_t  s_data  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    pwm_pdc_out_t m_data;

    pwm_pdc_out_t pending_words[$];   // expected results, oldest first
    int           mismatch_cnt = 0;
    bit           tx_idle = 1'b1;     // source inserts gaps
    bit           rx_idle = 1'b1;     // sink inserts stalls
    bit           hold_req = 1'b0;    // ask sink for one long hold-off

    // Directed rows: clamp edges on both sides, duty 0/100/255, full-scale bit patterns.
    dir_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{16'd0,     8'd0,   1'b1, 19'd337500, 20'd0},       // below range, zero duty
        '{16'd0,     8'd255, 1'b1, 19'd337500, 20'd860625},  // largest mark
        '{16'd65535, 8'd255, 1'b1, 19'd168,    20'd428},     // all ones
        '{16'd65535, 8'd0,   1'b1, 19'd168,    20'd0},
        '{16'd9,     8'd100, 1'b1, 19'd337500, 20'd337500},  // just under min
        '{16'd10,    8'd100, 1'b1, 19'd337500, 20'd337500},  // at min
        '{16'd11,    8'd100, 1'b0, 19'd0,      20'd0},
        '{16'd19999, 8'd100, 1'b0, 19'd0,      20'd0},
        '{16'd20000, 8'd100, 1'b1, 19'd168,    20'd168},     // at max
        '{16'd20001, 8'd1,   1'b1, 19'd168,    20'd1},       // just over max
        '{16'd1000,  8'd50,  1'b0, 19'd0,      20'd0},
        '{16'd1000,  8'd101, 1'b0, 19'd0,      20'd0},       // duty over 100
        '{16'd50,    8'd0,   1'b0, 19'd0,      20'd0},
        '{16'd1,     8'd1,   1'b1, 19'd337500, 20'd3375},
        '{16'd32768, 8'd128, 1'b1, 19'd168,    20'd215},
        '{16'd255,   8'd254, 1'b0, 19'd0,      20'd0},
        '{16'd21845, 8'd170, 1'b0, 19'd0,      20'd0},       // alternating bits
        '{16'd43690, 8'd85,  1'b0, 19'd0,      20'd0}
    };

    pwm_period_duty_calc_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Clamp the frequency, divide the oscillator down, then scale by duty.
    // All intermediates fit in 32 bits (worst product 337500 * 255).
    function automatic pwm_pdc_out_t calc_pwm_words(pwm_pdc_in_t req);
        logic [FREQ_W-1:0] freq;
        logic [31:0]       period;
        logic [31:0]       mark;
        pwm_pdc_out_t      words;
        freq = req.freq_hz;
        if (freq > FREQ_MAX_HZ) freq = FREQ_MAX_HZ[FREQ_W-1:0];
        if (freq < FREQ_MIN_HZ) freq = FREQ_MIN_HZ[FREQ_W-1:0];
        period = OSC_RATE_HZ / (32'(freq) * FIXED_DIVISOR);
        mark   = (period * 32'(req.duty_pct)) / PCT_SCALE;
        words.range_word = period[RANGE_W-1:0];
        words.mark_word  = mark[MARK_W-1:0];
        return words;
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item; valid stays up with stable data until the handshake.
    task automatic offer_item(input pwm_pdc_in_t req, input pwm_pdc_out_t words);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_words.push_back(words);
    endtask

    // Random request: mostly in range, with below-min, above-max and full-range
    // frequencies mixed in; duty mostly 0..100, sometimes the whole byte.
    function automatic pwm_pdc_in_t rand_request();
        pwm_pdc_in_t req;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 70)      req.freq_hz = FREQ_W'($urandom_range(FREQ_MIN_HZ, FREQ_MAX_HZ));
        else if (r < 80) req.freq_hz = FREQ_W'($urandom_range(0, FREQ_MIN_HZ - 1));
        else if (r < 90) req.freq_hz = FREQ_W'($urandom_range(FREQ_MAX_HZ + 1, 65535));
        else             req.freq_hz = FREQ_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 80) req.duty_pct = DUTY_W'($urandom_range(0, PCT_SCALE));
        else                            req.duty_pct = DUTY_W'($urandom_range(0, 255));
        return req;
    endfunction

    // Stimulus and end-of-run decision.
    initial begin
        pwm_pdc_in_t  req;
        pwm_pdc_out_t words;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            req.freq_hz  = directed_rows[i].freq;
            req.duty_pct = directed_rows[i].duty;
            if (directed_rows[i].known) begin
                words.range_word = directed_rows[i].range_word;
                words.mark_word  = directed_rows[i].mark_word;
            end else begin
                words = calc_pwm_words(req);
            end
            offer_item(req, words);
        end

        // Random blocks; each block picks its own idling mix. One block runs
        // back to back while the sink holds off, so the pipe fills and s_ready drops.
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            if (b == RAND_BLOCKS / 2) begin
                tx_idle  = 1'b0;
                rx_idle  = 1'b0;
                hold_req = 1'b1;
            end else begin
                tx_idle = ($urandom_range(0, 4) != 0);
                rx_idle = ($urandom_range(0, 4) != 0);
            end
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
                req = rand_request();
                offer_item(req, calc_pwm_words(req));
            end
        end
        s_valid <= 1'b0;

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Sink: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = rx_idle ? pick_gap() : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end else begin
                    m_ready <= 1'b1;
                    @(posedge aclk);
                end
            end
        end
    end

    // Scoreboard: each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        pwm_pdc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result with nothing expected: range_word %0d mark_word %0d",
                       m_data.range_word, m_data.mark_word);
                mismatch_cnt++;
            end else begin
                want = pending_words.pop_front();
                if (m_data.range_word !== want.range_word) begin
                    $error("range_word: expected %0d, actual %0d",
                           want.range_word, m_data.range_word);
                    mismatch_cnt++;
                end
                if (m_data.mark_word !== want.mark_word) begin
                    $error("mark_word: expected %0d, actual %0d",
                           want.mark_word, m_data.mark_word);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
